FILE: hw/rtl/lwri_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwri_pkg
// Shared widths, register indexes, side-band types and the cosine / warp
// factor functions used to build the factor table at elaboration.
// ----------------------------------------------------------------------------
package lwri_pkg;

   // field and register widths
   localparam int unsigned COORD_W   = 12;
   localparam int unsigned DIM_W     = 13;
   localparam int unsigned INDEX_W   = 24;
   localparam int unsigned FACTOR_W  = 16;
   localparam int unsigned SIGNED_W  = COORD_W + 2;

   // frame limits and reset values
   localparam int unsigned MAX_DIM          = 4096;
   localparam int unsigned WIDTH_RESET      = 320;
   localparam int unsigned HEIGHT_RESET     = 200;
   localparam int unsigned COS_TABLE_DEPTH_DEF = 1024;

   // configuration register indexes
   typedef enum logic [0:0] {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   // coordinate data carried next to the phase dividers
   typedef struct packed {
      logic [COORD_W-1:0] mag_x;
      logic [COORD_W-1:0] mag_y;
      logic               neg_x;
      logic               neg_y;
   } side_type;

   // Q30 fixed point helpers for the table build
   localparam longint unsigned Q30_ONE     = 64'd1073741824;
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
   localparam longint          F_BASE_RND  = 64'sd966377472;   // base plus rounding half
   localparam longint          F_AMP       = 64'sd3277;

   // Cosine table entry, Q1.15. Entry k covers phase k / depth turns; the
   // caller passes 32 - log2(depth) as shift.
   function automatic longint cos_entry(input longint unsigned k,
                                        input int unsigned     shift);
      longint unsigned u;
      longint unsigned r;
      longint unsigned a;
      longint unsigned a2;
      longint unsigned term;
      longint          c;
      longint          s;
      longint          v;
      longint unsigned mag;
      logic [1:0]      q;
      u    = k << shift;
      q    = u[31:30];
      r    = u & (Q30_ONE - 64'd1);
      a    = (r * HALF_PI_Q30) >> 30;
      a2   = (a * a) >> 30;
      // cosine series, terms up to a^14/14!
      term = Q30_ONE;
      c    = longint'(term);
      term = ((term * a2) >> 30) / 2;   c = c - longint'(term);
      term = ((term * a2) >> 30) / 12;  c = c + longint'(term);
      term = ((term * a2) >> 30) / 30;  c = c - longint'(term);
      term = ((term * a2) >> 30) / 56;  c = c + longint'(term);
      term = ((term * a2) >> 30) / 90;  c = c - longint'(term);
      term = ((term * a2) >> 30) / 132; c = c + longint'(term);
      term = ((term * a2) >> 30) / 182; c = c - longint'(term);
      // sine series, terms up to a^13/13!
      term = a;
      s    = longint'(term);
      term = ((term * a2) >> 30) / 6;   s = s - longint'(term);
      term = ((term * a2) >> 30) / 20;  s = s + longint'(term);
      term = ((term * a2) >> 30) / 42;  s = s - longint'(term);
      term = ((term * a2) >> 30) / 72;  s = s + longint'(term);
      term = ((term * a2) >> 30) / 110; s = s - longint'(term);
      term = ((term * a2) >> 30) / 156; s = s + longint'(term);
      case (q)
         2'd0:    v = c;
         2'd1:    v = -s;
         2'd2:    v = -c;
         default: v = s;
      endcase
      // round half away from zero to Q15, saturate
      mag = (v < 0) ? longint'(-v) : longint'(v);
      mag = (mag + 64'd16384) >> 15;
      if (mag > 64'd32767) begin
         mag = 64'd32767;
      end
      return (v < 0) ? -longint'(mag) : longint'(mag);
   endfunction

   // Warp factor 0.9 - 0.1*cos, unsigned Q1.15
   function automatic logic [FACTOR_W-1:0] warp_factor(input longint unsigned k,
                                                       input int unsigned     shift);
      longint c;
      longint f;
      c = cos_entry(k, shift);
      f = (F_BASE_RND - F_AMP * c) >>> 15;
      return f[FACTOR_W-1:0];
   endfunction

endpackage

FILE: hw/rtl/lwri_phase_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwri_phase_div
// Pipelined restoring divider, one quotient bit per stage. Gives the low
// PHASE_W bits of floor(mag * 2^PHASE_W / divisor), i.e. the table phase.
// ----------------------------------------------------------------------------
module lwri_phase_div #(
   parameter int unsigned PHASE_W = 10
) (
   input  logic                        clock,
   input  logic                        en,
   input  logic [lwri_pkg::COORD_W-1:0] mag,
   input  logic [lwri_pkg::DIM_W-1:0]   divisor,
   output logic [PHASE_W-1:0]           phase
);
   import lwri_pkg::*;

   localparam int unsigned NUM_W = COORD_W + PHASE_W;

   logic [DIM_W-1:0]   rem_ff [NUM_W];
   logic [NUM_W-1:0]   num_ff [NUM_W];
   logic [PHASE_W-1:0] quo_ff [NUM_W];

   // one compare and subtract per stage
   for (genvar s = 0; s < NUM_W; s++) begin : g_step
      logic [DIM_W-1:0]   rem_prev;
      logic [NUM_W-1:0]   num_prev;
      logic [PHASE_W-1:0] quo_prev;
      logic [DIM_W:0]     trial;
      logic [DIM_W:0]     diff;
      logic               fits;

      if (s == 0) begin : g_first
         assign rem_prev = '0;
         assign num_prev = {mag, {PHASE_W{1'b0}}};
         assign quo_prev = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[s-1];
         assign num_prev = num_ff[s-1];
         assign quo_prev = quo_ff[s-1];
      end

      assign trial = {rem_prev, num_prev[NUM_W-1]};
      assign diff  = trial - {1'b0, divisor};
      assign fits  = (trial >= {1'b0, divisor});

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s] <= fits ? diff[DIM_W-1:0] : trial[DIM_W-1:0];
            num_ff[s] <= {num_prev[NUM_W-2:0], 1'b0};
            quo_ff[s] <= {quo_prev[PHASE_W-2:0], fits};
         end
      end
   end

   assign phase = quo_ff[NUM_W-1];

endmodule

FILE: hw/rtl/lwri_factor_rom.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwri_factor_rom
// Warp factor table, one entry per cosine phase, two registered read ports.
// Contents are fixed at elaboration from the package functions.
// ----------------------------------------------------------------------------
module lwri_factor_rom #(
   parameter int unsigned DEPTH = 1024
) (
   input  logic                          clock,
   input  logic                          en,
   input  logic [$clog2(DEPTH)-1:0]      addr_a,
   input  logic [$clog2(DEPTH)-1:0]      addr_b,
   output logic [lwri_pkg::FACTOR_W-1:0] factor_a,
   output logic [lwri_pkg::FACTOR_W-1:0] factor_b
);
   import lwri_pkg::*;

   localparam int unsigned PHASE_W = $clog2(DEPTH);
   localparam int unsigned SHIFT   = 32 - PHASE_W;

   logic [FACTOR_W-1:0] rom [DEPTH];
   logic [FACTOR_W-1:0] factor_a_ff;
   logic [FACTOR_W-1:0] factor_b_ff;

   // constant contents
   for (genvar i = 0; i < DEPTH; i++) begin : g_rom
      assign rom[i] = warp_factor(longint'(i), SHIFT);
   end

   // registered reads
   always_ff @(posedge clock) begin
      if (en) begin
         factor_a_ff <= rom[addr_a];
         factor_b_ff <= rom[addr_b];
      end
   end

   assign factor_a = factor_a_ff;
   assign factor_b = factor_b_ff;

endmodule

FILE: hw/rtl/lens_warp_remap_index.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lens_warp_remap_index
// Maps a destination pixel to its source pixel under a cosine lens warp and
// gives the source coordinates and linear frame index.
//
//   channel  direction  payload (low bit first)
//   req_     in         dest_x[11:0], dest_y[23:12]
//   rsp_     out        src_x[11:0], src_y[23:12], src_index[47:24]
//   csr_     in         index 0 frame_width, index 1 frame_height
//
// One item per cycle sustained while the skid register is empty. Most of
// the pipe depth lies in the bit-per-stage phase dividers.
// Reset clears the pipe and loads frame_width 320, frame_height 200.
// A held result parks in a one-item skid register; the pipe freezes only
// while that register is full.
// ----------------------------------------------------------------------------
module lens_warp_remap_index #(
   parameter int unsigned COS_TABLE_DEPTH = lwri_pkg::COS_TABLE_DEPTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   // input items
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [23:0]                 req_tdata,   // dest_x, dest_y
   // result items
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [47:0]                 rsp_tdata,   // src_x, src_y, src_index
   // configuration writes
   input  logic                        csr_we,
   input  logic [0:0]                  csr_addr,
   input  logic [lwri_pkg::DIM_W-1:0]  csr_wdata
);
   import lwri_pkg::*;

   localparam int unsigned PHASE_W = $clog2(COS_TABLE_DEPTH);
   localparam int unsigned NSTEP   = COORD_W + PHASE_W;
   localparam int unsigned PX_W    = COORD_W + FACTOR_W;
   localparam int unsigned PXY_W   = PX_W + FACTOR_W;
   localparam int unsigned PIDX_W  = COORD_W + DIM_W;

   // configuration
   logic [DIM_W-1:0] frame_width_ff;
   logic [DIM_W-1:0] frame_height_ff;
   logic [DIM_W-1:0] w_eff;
   logic [DIM_W-1:0] h_eff;
   logic [COORD_W-1:0] half_w;
   logic [COORD_W-1:0] half_h;

   // pipe control
   logic en;
   logic skid_v_ff;
   logic rsp_v_ff;

   // stage 0: offsets from center
   logic                       v0_ff;
   side_type                   side0_ff;
   side_type                   side0_in;
   logic signed [SIGNED_W-1:0] dx;
   logic signed [SIGNED_W-1:0] dy;

   // side line beside the dividers
   logic                       sv_ff [NSTEP];
   side_type                   sd_ff [NSTEP];
   logic [PHASE_W-1:0]         phase_x;
   logic [PHASE_W-1:0]         phase_y;

   // stage 1: factors
   logic                       v1_ff;
   side_type                   side1_ff;
   logic [FACTOR_W-1:0]        fx1;
   logic [FACTOR_W-1:0]        fy1;

   // stage 2: first products
   logic                       v2_ff;
   logic [PX_W-1:0]            px2_ff;
   logic [PX_W-1:0]            py2_ff;
   logic [FACTOR_W-1:0]        fy2_ff;
   logic                       nx2_ff;
   logic                       ny2_ff;

   // stage 3: offset magnitudes
   logic                       v3_ff;
   logic [PXY_W-1:0]           pxy_in;
   logic [COORD_W-1:0]         oxm3_ff;
   logic [COORD_W-1:0]         oym3_ff;
   logic                       nx3_ff;
   logic                       ny3_ff;

   // stage 4: recentred and clamped
   logic                       v4_ff;
   logic [COORD_W-1:0]         sx4_ff;
   logic [COORD_W-1:0]         sy4_ff;
   logic [COORD_W-1:0]         sx4_in;
   logic [COORD_W-1:0]         sy4_in;

   // stage 5: row product
   logic                       v5_ff;
   logic [PIDX_W-1:0]          prod5_in;
   logic [INDEX_W-1:0]         prod5_ff;
   logic [COORD_W-1:0]         sx5_ff;
   logic [COORD_W-1:0]         sy5_ff;

   // output and skid
   logic [47:0]                fin;
   logic [INDEX_W-1:0]         idx_in;
   logic [47:0]                rsp_d_ff;
   logic [47:0]                skid_d_ff;

   // ------------------------------------------------------------------
   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= DIM_W'(WIDTH_RESET);
         frame_height_ff <= DIM_W'(HEIGHT_RESET);
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_addr))
            CSR_FRAME_WIDTH:  frame_width_ff  <= csr_wdata;
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // effective frame size, zero acts as one, capped at MAX_DIM
   function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
      if (v == '0) begin
         return DIM_W'(1);
      end else if (v > DIM_W'(MAX_DIM)) begin
         return DIM_W'(MAX_DIM);
      end
      return v;
   endfunction

   assign w_eff  = eff_dim(frame_width_ff);
   assign h_eff  = eff_dim(frame_height_ff);
   assign half_w = w_eff[DIM_W-1:1];
   assign half_h = h_eff[DIM_W-1:1];

   // ------------------------------------------------------------------
   // pipe advances unless the skid register holds an item
   assign en         = ~skid_v_ff;
   assign req_tready = en;

   // stage 0: signed offsets, magnitudes
   always_comb begin
      dx = $signed({2'b00, req_tdata[COORD_W-1:0]}) - $signed({2'b00, half_w});
      dy = $signed({2'b00, req_tdata[2*COORD_W-1:COORD_W]}) - $signed({2'b00, half_h});
      side0_in.neg_x = dx[SIGNED_W-1];
      side0_in.neg_y = dy[SIGNED_W-1];
      side0_in.mag_x = dx[SIGNED_W-1] ? COORD_W'(-dx) : COORD_W'(dx);
      side0_in.mag_y = dy[SIGNED_W-1] ? COORD_W'(-dy) : COORD_W'(dy);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side0_ff <= side0_in;
      end
   end

   // phase dividers, both by the frame width (cosine period)
   lwri_phase_div #(.PHASE_W(PHASE_W)) u_div_x (
      .clock   (clock),
      .en      (en),
      .mag     (side0_ff.mag_x),
      .divisor (w_eff),
      .phase   (phase_x)
   );

   lwri_phase_div #(.PHASE_W(PHASE_W)) u_div_y (
      .clock   (clock),
      .en      (en),
      .mag     (side0_ff.mag_y),
      .divisor (w_eff),
      .phase   (phase_y)
   );

   // side line matching the divider depth
   for (genvar s = 0; s < NSTEP; s++) begin : g_side
      always_ff @(posedge clock) begin
         if (reset) begin
            sv_ff[s] <= 1'b0;
         end else if (en) begin
            sv_ff[s] <= (s == 0) ? v0_ff : sv_ff[(s == 0) ? 0 : s-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            sd_ff[s] <= (s == 0) ? side0_ff : sd_ff[(s == 0) ? 0 : s-1];
         end
      end
   end

   // stage 1: factor lookup
   lwri_factor_rom #(.DEPTH(COS_TABLE_DEPTH)) u_rom (
      .clock    (clock),
      .en       (en),
      .addr_a   (phase_x),
      .addr_b   (phase_y),
      .factor_a (fx1),
      .factor_b (fy1)
   );

   // valid bits of stages 1 to 5
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= sv_ff[NSTEP-1];
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   // stage 3 product and stage 4 recentre / clamp
   assign pxy_in = PXY_W'(px2_ff) * PXY_W'(fy2_ff);

   function automatic logic [COORD_W-1:0] place(input logic [COORD_W-1:0] mag,
                                                input logic               neg,
                                                input logic [COORD_W-1:0] half,
                                                input logic [DIM_W-1:0]   dim);
      logic signed [SIGNED_W-1:0] ofs;
      logic signed [SIGNED_W-1:0] pos;
      ofs = $signed({2'b00, mag});
      pos = (neg ? -ofs : ofs) + $signed({2'b00, half});
      if (pos < 0) begin
         return '0;
      end else if (pos >= $signed({1'b0, dim})) begin
         return COORD_W'(dim - 1'b1);
      end
      return pos[COORD_W-1:0];
   endfunction

   assign sx4_in   = place(oxm3_ff, nx3_ff, half_w, w_eff);
   assign sy4_in   = place(oym3_ff, ny3_ff, half_h, h_eff);
   assign prod5_in = PIDX_W'(sy4_ff) * PIDX_W'(w_eff);

   // payload of stages 1 to 5
   always_ff @(posedge clock) begin
      if (en) begin
         side1_ff <= sd_ff[NSTEP-1];
         // stage 2
         px2_ff   <= PX_W'(side1_ff.mag_x) * PX_W'(fx1);
         py2_ff   <= PX_W'(side1_ff.mag_y) * PX_W'(fy1);
         fy2_ff   <= fy1;
         nx2_ff   <= side1_ff.neg_x;
         ny2_ff   <= side1_ff.neg_y;
         // stage 3: drop the Q30 and Q15 fractions
         oxm3_ff  <= pxy_in[30 +: COORD_W];
         oym3_ff  <= py2_ff[15 +: COORD_W];
         nx3_ff   <= nx2_ff;
         ny3_ff   <= ny2_ff;
         // stage 4
         sx4_ff   <= sx4_in;
         sy4_ff   <= sy4_in;
         // stage 5
         prod5_ff <= prod5_in[INDEX_W-1:0];
         sx5_ff   <= sx4_ff;
         sy5_ff   <= sy4_ff;
      end
   end

   // final index add
   assign idx_in = prod5_ff + INDEX_W'(sx5_ff);
   assign fin    = {idx_in, sy5_ff, sx5_ff};

   // ------------------------------------------------------------------
   // output register with one-item skid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (!skid_v_ff) begin
         if (!rsp_v_ff || rsp_tready) begin
            rsp_v_ff <= v5_ff;
         end else if (v5_ff) begin
            skid_v_ff <= 1'b1;
         end
      end else if (rsp_tready) begin
         skid_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (!skid_v_ff) begin
         if (!rsp_v_ff || rsp_tready) begin
            rsp_d_ff <= fin;
         end else begin
            skid_d_ff <= fin;
         end
      end else if (rsp_tready) begin
         rsp_d_ff <= skid_d_ff;
      end
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = rsp_d_ff;

endmodule

FILE: hw/rtl/lwri_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwri_checker
// Port-level checks on the stall behavior of lens_warp_remap_index.
// ----------------------------------------------------------------------------
module lwri_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata
);

   // input side stalls only while a result is on offer
   a_stall_needs_result: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("input stalled with no result pending");

   // ready drops only after a result was refused
   a_ready_fall: assert property (@(posedge clock) disable iff (reset)
      $fell(req_tready) |-> $past(rsp_tvalid && !rsp_tready))
      else $error("input ready fell without an output stall");

   // ready returns only once a held result is taken
   a_ready_rise: assert property (@(posedge clock) disable iff (reset)
      $rose(req_tready) |-> $past(rsp_tvalid && rsp_tready))
      else $error("input ready rose without an output transfer");

   // a refused result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

endmodule

bind lens_warp_remap_index lwri_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
